// ===== rtl/wbla_pkg.sv =====
package wbla_pkg;

	localparam int unsigned XLEN            = 32;
	localparam int unsigned REG_W           = 5;
	localparam int unsigned LANE_W          = 32;
	localparam int unsigned MAX_LANES       = 2;
	localparam int unsigned DERIV_W         = LANE_W * MAX_LANES;
	localparam int unsigned DERIV_LANES_DEF = 2;

	typedef enum logic [1:0] {
		KIND_IDLE = 2'd0,
		KIND_EXEC = 2'd1,
		KIND_MEM  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		LD_LB  = 3'd0,
		LD_LH  = 3'd1,
		LD_LW  = 3'd2,
		LD_LBU = 3'd4,
		LD_LHU = 3'd5
	} load_size_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [REG_W-1:0]   dest_reg;
		logic               no_dest;
		logic               is_deriv_op;
		logic [XLEN-1:0]    data_word;
		logic [1:0]         byte_offset;
		logic               half_select;
		logic [2:0]         load_size;
		logic               is_raw_pack;
		logic [DERIV_W-1:0] deriv_data;
		logic               is_return;
		logic               is_exit;
	} item_t;

	typedef struct packed {
		logic [REG_W-1:0]   dest_out;
		logic               gp_write;
		logic [XLEN-1:0]    gp_value;
		logic               deriv_write;
		logic [DERIV_W-1:0] deriv_value;
		logic               return_flag;
		logic               exit_flag;
	} result_t;

	typedef struct packed {
		logic ret;
		logic halt;
	} hold_t;

endpackage

// ===== rtl/wbla_item_if.sv =====
interface wbla_item_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic [wbla_pkg::REG_W-1:0]   dest_reg;
	logic                         no_dest;
	logic                         is_deriv_op;
	logic [wbla_pkg::XLEN-1:0]    data_word;
	logic [1:0]                   byte_offset;
	logic                         half_select;
	logic [2:0]                   load_size;
	logic                         is_raw_pack;
	logic [wbla_pkg::DERIV_W-1:0] deriv_data;
	logic                         is_return;
	logic                         is_exit;

	modport source (
		output valid, kind, dest_reg, no_dest, is_deriv_op, data_word, byte_offset,
		       half_select, load_size, is_raw_pack, deriv_data, is_return, is_exit,
		input  ready
	);

	modport sink (
		input  valid, kind, dest_reg, no_dest, is_deriv_op, data_word, byte_offset,
		       half_select, load_size, is_raw_pack, deriv_data, is_return, is_exit,
		output ready
	);
endinterface

// ===== rtl/wbla_result_if.sv =====
interface wbla_result_if;
	logic                         valid;
	logic                         ready;
	logic [wbla_pkg::REG_W-1:0]   dest_out;
	logic                         gp_write;
	logic [wbla_pkg::XLEN-1:0]    gp_value;
	logic                         deriv_write;
	logic [wbla_pkg::DERIV_W-1:0] deriv_value;
	logic                         return_flag;
	logic                         exit_flag;

	modport source (
		output valid, dest_out, gp_write, gp_value, deriv_write, deriv_value,
		       return_flag, exit_flag,
		input  ready
	);

	modport sink (
		input  valid, dest_out, gp_write, gp_value, deriv_write, deriv_value,
		       return_flag, exit_flag,
		output ready
	);
endinterface

// ===== rtl/riscv_writeback_load_align.sv =====
// Write-back stage with load alignment and derivative lanes.
// An input register and a result register part the two sides; each word passes both in turn.
// Throughput: one word per cycle unless result.ready stalls it.
// The stored return and exit markers update in the order words leave the input register.
// Reset clears both valid bits and the stored markers; payload registers are not reset.
module riscv_writeback_load_align #(
	parameter int unsigned DERIV_LANES = wbla_pkg::DERIV_LANES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	wbla_item_if.sink            item,
	wbla_result_if.source        result
);
	import wbla_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_d;
	hold_t   hold_q;
	hold_t   hold_d;
	logic    ready_s1;
	logic    ready_s2;
	logic    advance;

	assign ready_s2   = !valid_s2 || result.ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign advance    = valid_s1 && ready_s2;
	assign item.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && item.valid) begin
			item_s1 <= '{
				kind:        item.kind,
				dest_reg:    item.dest_reg,
				no_dest:     item.no_dest,
				is_deriv_op: item.is_deriv_op,
				data_word:   item.data_word,
				byte_offset: item.byte_offset,
				half_select: item.half_select,
				load_size:   item.load_size,
				is_raw_pack: item.is_raw_pack,
				deriv_data:  item.deriv_data,
				is_return:   item.is_return,
				is_exit:     item.is_exit
			};
		end
	end

	wbla_compute #(
		.DERIV_LANES (DERIV_LANES)
	) u_compute (
		.item      (item_s1),
		.hold      (hold_q),
		.res       (res_d),
		.hold_next (hold_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			hold_q   <= '0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				hold_q <= hold_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid       = valid_s2;
	assign result.dest_out    = res_s2.dest_out;
	assign result.gp_write    = res_s2.gp_write;
	assign result.gp_value    = res_s2.gp_value;
	assign result.deriv_write = res_s2.deriv_write;
	assign result.deriv_value = res_s2.deriv_value;
	assign result.return_flag = res_s2.return_flag;
	assign result.exit_flag   = res_s2.exit_flag;

	// Register zero is only ever written with zero, both general and derivative.
	a_x0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.gp_write && (res_s2.dest_out == '0)
		|-> (res_s2.gp_value == '0) && (res_s2.deriv_value == '0))
		else $error("register zero written with a non-zero value");

	// Both register files are written together or not at all.
	a_write_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.gp_write == res_s2.deriv_write))
		else $error("general and derivative write enables disagree");

	// The stored return marker is cleared by every memory word that moves on.
	a_mem_clears_ret: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_t'(item_s1.kind) == KIND_MEM) |=> !hold_q.ret)
		else $error("return marker survived a memory word");

	// Lanes beyond the configured count stay zero.
	a_unused_lane: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (DERIV_LANES > 1) || (res_s2.deriv_value[DERIV_W-1:LANE_W] == '0))
		else $error("unused derivative lane carries data");
endmodule

// ===== rtl/wbla_extract.sv =====
module wbla_extract (
	input  logic [wbla_pkg::XLEN-1:0] word,
	input  logic [1:0]                byte_offset,
	input  logic                      half_select,
	input  logic [2:0]                load_size,
	input  logic                      is_raw_pack,
	output logic [wbla_pkg::XLEN-1:0] value
);
	import wbla_pkg::*;

	logic [7:0]  sel_byte;
	logic [15:0] sel_half;

	always_comb begin
		case (byte_offset)
			2'd0:    sel_byte = word[7:0];
			2'd1:    sel_byte = word[15:8];
			2'd2:    sel_byte = word[23:16];
			default: sel_byte = word[31:24];
		endcase
		sel_half = half_select ? word[31:16] : word[15:0];
	end

	always_comb begin
		if (is_raw_pack) begin
			value = word;
		end else begin
			case (load_size_t'(load_size))
				LD_LB:   value = {{(XLEN-8){sel_byte[7]}}, sel_byte};
				LD_LH:   value = {{(XLEN-16){sel_half[15]}}, sel_half};
				LD_LW:   value = word;
				LD_LBU:  value = {{(XLEN-8){1'b0}}, sel_byte};
				LD_LHU:  value = {{(XLEN-16){1'b0}}, sel_half};
				default: value = '0;
			endcase
		end
	end
endmodule

// ===== rtl/wbla_compute.sv =====
module wbla_compute #(
	parameter int unsigned DERIV_LANES = wbla_pkg::DERIV_LANES_DEF
) (
	input  wbla_pkg::item_t   item,
	input  wbla_pkg::hold_t   hold,
	output wbla_pkg::result_t res,
	output wbla_pkg::hold_t   hold_next
);
	import wbla_pkg::*;

	logic [XLEN-1:0]    mem_value;
	logic [DERIV_W-1:0] mem_lanes;
	logic [DERIV_W-1:0] exec_lanes;
	logic [XLEN-1:0]    value;
	logic [DERIV_W-1:0] lanes;
	logic               active;
	logic               is_mem;

	wbla_extract u_gp_extract (
		.word        (item.data_word),
		.byte_offset (item.byte_offset),
		.half_select (item.half_select),
		.load_size   (item.load_size),
		.is_raw_pack (item.is_raw_pack),
		.value       (mem_value)
	);

	for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
		if (k < DERIV_LANES) begin : g_used
			wbla_extract u_lane_extract (
				.word        (item.deriv_data[k*LANE_W +: LANE_W]),
				.byte_offset (item.byte_offset),
				.half_select (item.half_select),
				.load_size   (item.load_size),
				.is_raw_pack (item.is_raw_pack),
				.value       (mem_lanes[k*LANE_W +: LANE_W])
			);
			assign exec_lanes[k*LANE_W +: LANE_W] = item.deriv_data[k*LANE_W +: LANE_W];
		end else begin : g_unused
			assign mem_lanes[k*LANE_W +: LANE_W]  = '0;
			assign exec_lanes[k*LANE_W +: LANE_W] = '0;
		end
	end

	always_comb begin
		is_mem = (kind_t'(item.kind) == KIND_MEM);
		active = (kind_t'(item.kind) == KIND_EXEC) || is_mem;
		value  = is_mem ? mem_value : item.data_word;
		lanes  = is_mem ? mem_lanes : exec_lanes;

		hold_next = hold;
		if (active) begin
			if (is_mem) begin
				hold_next.ret = 1'b0;
			end else begin
				hold_next.ret  = item.is_return;
				hold_next.halt = item.is_exit;
			end
		end

		res             = '0;
		res.return_flag = hold_next.ret;
		res.exit_flag   = hold_next.halt;
		if (active) begin
			res.dest_out = item.dest_reg;
			if (!item.no_dest) begin
				res.gp_write    = 1'b1;
				res.deriv_write = 1'b1;
				if (item.dest_reg != '0) begin
					res.gp_value    = value;
					res.deriv_value = item.is_deriv_op ? lanes : '0;
				end
			end
		end
	end
endmodule
